// ===== sv/idct_8x8_level_shift_top_assert.svh =====
// Assertion macros shared by the checker.
`ifndef IDCT_8X8_LEVEL_SHIFT_TOP_ASSERT_SVH
`define IDCT_8X8_LEVEL_SHIFT_TOP_ASSERT_SVH
// Implication checked on every rising clock edge outside reset.
`define IDCT_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication.
`define IDCT_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== sv/idct_pkg.sv =====
// Shared types, constants and cosine table of the 8x8 inverse DCT.
`default_nettype none
package idct_pkg;
  localparam int CoeffBits   = 16;
  localparam int TabFrac     = 14;
  localparam int OutFrac     = 4;
  localparam int SampleBits  = 24;
  localparam int AccBits     = 48;
  localparam logic signed [SampleBits-1:0] SampleMax = 24'sh7FFFFF;
  localparam logic signed [SampleBits-1:0] SampleMin = -24'sh800000;

  typedef enum logic [1:0] {
    StLoad, StRow, StCol
  } state_e;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    logic       clr;   // start a new sum
    logic       mac;   // accumulate one product
    logic       col;   // column pass operand and rounding
    logic [2:0] k;     // tap index
    logic [2:0] x;     // output index within line
    logic [2:0] y;     // line index
  } ctrl_t;

  // 0.5*C(u)*cos((2x+1)u*pi/16), 14 fraction bits
  function automatic logic signed [15:0] cos_tab(input logic [2:0] x, input logic [2:0] u);
    logic [4:0] m;
    logic neg;
    logic signed [15:0] v;
    m = 5'(({2'b0, x, 1'b1}) * {3'b0, u});
    neg = 1'b0;
    if (m > 5'd16) m = 5'd0 - m;
    if (m > 5'd8) begin
      m = 5'd16 - m;
      neg = 1'b1;
    end
    case (m)
      5'd0: v = 16'sd8192;
      5'd1: v = 16'sd8035;
      5'd2: v = 16'sd7568;
      5'd3: v = 16'sd6811;
      5'd4: v = 16'sd5793;
      5'd5: v = 16'sd4551;
      5'd6: v = 16'sd3135;
      5'd7: v = 16'sd1598;
      default: v = 16'sd0;
    endcase
    if (u == 3'd0) v = 16'sd5793;
    else if (neg) v = -v;
    return v;
  endfunction
endpackage
`default_nettype wire

// ===== sv/idct_8x8_level_shift_top.sv =====
// Top level of the 8x8 inverse DCT with level shift.
// Use: stream 64 dequantized coefficients (row-major) on s_axis, whose
// tready stays high while loading. After the 64th beat s_axis_tready
// drops and one shared 24x16 multiply-accumulate unit runs 512 row taps and
// 512 column taps, one tap a cycle while no full output register holds the
// column pass. No new coefficient is taken until both passes end, so the
// block rate is set by the single MAC. Samples leave on m_axis in row-major
// order, tlast on the 64th.
// cfg_valid_i/cfg_ready_o writes sample precision; write only when idle.
// Reset clears the coefficient count and sequencer; precision resets to 8.
// A stalled receiver holds the output register; the MAC waits on the final
// tap of the next sample until the register frees, so nothing is lost;
// such stalls lengthen the block.
`default_nettype none
module idct_8x8_level_shift_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // [15:0] coefficient
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [23:0] sample
  output logic             m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [4:0]  cfg_data_i
);
  import idct_pkg::*;
  ctrl_t ctrl;
  logic in_fire, res, full, out_vld;
  logic [5:0] wr_cnt, idx;
  logic [4:0] prec_q;
  logic signed [23:0] sample;
  logic vld_q, last_q;
  logic [23:0] data_q;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign full = vld_q && !m_axis_tready;
  assign cfg_ready_o = 1'b1;

  idct_seq u_seq (
    .clk_i, .rst_ni, .in_fire_i(in_fire), .out_full_i(full),
    .in_ready_o(s_axis_tready), .wr_cnt_o(wr_cnt), .ctrl_o(ctrl), .res_o(res)
  );
  idct_mac u_mac (
    .clk_i, .in_fire_i(in_fire), .wr_cnt_i(wr_cnt), .coef_i(s_axis_tdata),
    .ctrl_i(ctrl), .res_i(res), .prec_i(prec_q), .sample_o(sample), .idx_o(idx),
    .out_vld_o(out_vld)
  );

  // a column result only arrives when the sequencer saw the register free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prec_q <= 5'd8;
      vld_q <= 1'b0;
    end else begin
      if (cfg_valid_i) prec_q <= cfg_data_i;
      if (out_vld) vld_q <= 1'b1;
      else if (m_axis_tready) vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_vld) begin
      data_q <= sample;
      last_q <= (idx == 6'd63);
    end
  end
  assign m_axis_tvalid = vld_q;
  assign m_axis_tdata = data_q;
  assign m_axis_tlast = last_q;
endmodule
`default_nettype wire

// ===== sv/idct_seq.sv =====
// Sequencer: counts coefficients, steps the MAC through row and column passes.
`default_nettype none
module idct_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_fire_i,
  input  wire logic           out_full_i,
  output logic                in_ready_o,
  output logic [5:0]          wr_cnt_o,
  output idct_pkg::ctrl_t     ctrl_o,
  output logic                res_o
);
  import idct_pkg::*;
  state_e st_q, st_d;
  logic [5:0] cnt_q, cnt_d;
  logic [8:0] it_q, it_d;   // {y,x,k}
  logic res_q, res_d;

  always_comb begin
    st_d = st_q;
    case (st_q)
      StLoad: if (in_fire_i && cnt_q == 6'd63) st_d = StRow;
      StRow:  if (it_q == 9'h1FF) st_d = StCol;
      StCol:  if (it_q == 9'h1FF && !out_full_i) st_d = StLoad;
      default: st_d = StLoad;
    endcase
  end

  always_comb begin
    cnt_d = in_fire_i ? cnt_q + 6'd1 : cnt_q;
    it_d = it_q;
    res_d = 1'b0;
    in_ready_o = (st_q == StLoad);
    ctrl_o.k = it_q[2:0];
    ctrl_o.x = it_q[5:3];
    ctrl_o.y = it_q[8:6];
    ctrl_o.col = (st_q == StCol);
    ctrl_o.clr = (it_q[2:0] == 3'd0);
    ctrl_o.mac = 1'b0;
    case (st_q)
      StRow: begin
        ctrl_o.mac = 1'b1;
        it_d = it_q + 9'd1;
        res_d = (it_q[2:0] == 3'd7);
      end
      StCol: begin
        // hold at the last tap while the output register is still full
        if (!(it_q[2:0] == 3'd7 && out_full_i)) begin
          ctrl_o.mac = 1'b1;
          it_d = it_q + 9'd1;
          res_d = (it_q[2:0] == 3'd7);
        end
      end
      default: it_d = 9'd0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad;
      cnt_q <= 6'd0;
      it_q <= 9'd0;
      res_q <= 1'b0;
    end else begin
      st_q <= st_d;
      cnt_q <= cnt_d;
      it_q <= it_d;
      res_q <= res_d;
    end
  end
  assign wr_cnt_o = cnt_q;
  assign res_o = res_q;
endmodule
`default_nettype wire

// ===== sv/idct_mac.sv =====
// Stores and shared multiply-accumulate unit with rounding and saturation.
`default_nettype none
module idct_mac (
  input  wire logic                     clk_i,
  input  wire logic                     in_fire_i,
  input  wire logic [5:0]               wr_cnt_i,
  input  wire logic signed [15:0]       coef_i,
  input  wire idct_pkg::ctrl_t          ctrl_i,
  input  wire logic                     res_i,
  input  wire logic [4:0]               prec_i,
  output logic signed [23:0]            sample_o,
  output logic [5:0]                    idx_o,
  output logic                          out_vld_o
);
  import idct_pkg::*;
  logic signed [CoeffBits-1:0] cmem [64];
  logic signed [SampleBits-1:0] rmem [64];
  logic signed [SampleBits-1:0] op_q;
  logic signed [15:0] c_q;
  logic signed [SampleBits+15:0] prod;
  logic signed [AccBits-1:0] acc_q, sum;
  logic mac_q, clr_q, col_q;
  logic [5:0] idx_q;
  logic acol_q, ares_q;
  logic [5:0] aidx_q;
  logic signed [AccBits-1:0] rnd, lvl, val;
  logic signed [SampleBits-1:0] sat;

  always_ff @(posedge clk_i) begin
    if (in_fire_i) cmem[wr_cnt_i] <= coef_i;
  end

  // stage 1: operand reads
  always_ff @(posedge clk_i) begin
    if (ctrl_i.col) begin
      op_q <= rmem[{ctrl_i.k, ctrl_i.x}];
      c_q <= cos_tab(ctrl_i.y, ctrl_i.k);
    end else begin
      op_q <= SampleBits'(cmem[{ctrl_i.y, ctrl_i.k}]);
      c_q <= cos_tab(ctrl_i.x, ctrl_i.k);
    end
    mac_q <= ctrl_i.mac;
    clr_q <= ctrl_i.clr;
    col_q <= ctrl_i.col;
    if (ctrl_i.mac) idx_q <= {ctrl_i.y, ctrl_i.x};
  end

  // stage 2: multiply-accumulate; pass flag, index and result strobe follow the sum
  assign prod = op_q * c_q;
  assign sum = (clr_q ? '0 : acc_q) + AccBits'(prod);
  always_ff @(posedge clk_i) begin
    if (mac_q) acc_q <= sum;
    acol_q <= col_q;
    aidx_q <= idx_q;
    ares_q <= res_i;
  end

  // round ties up, level shift in the column pass, saturate
  always_comb begin
    if (acol_q) begin
      rnd = (acc_q + AccBits'(1 << (TabFrac - 1))) >>> TabFrac;
      lvl = (prec_i == 5'd0) ? '0 :
            (AccBits'(1) << (6'(prec_i) + 6'(OutFrac - 1)));
    end else begin
      rnd = (acc_q + AccBits'(1 << (TabFrac - OutFrac - 1))) >>> (TabFrac - OutFrac);
      lvl = '0;
    end
    val = rnd + lvl;
    if (val > AccBits'(SampleMax)) sat = SampleMax;
    else if (val < AccBits'(SampleMin)) sat = SampleMin;
    else sat = val[SampleBits-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (ares_q && !acol_q) rmem[aidx_q] <= sat;
  end
  assign sample_o = sat;
  assign idx_o = aidx_q;
  assign out_vld_o = ares_q && acol_q;
endmodule
`default_nettype wire

// ===== sv/idct_8x8_level_shift_checker.sv =====
// Port-level checker for the inverse DCT top, with bind.
`default_nettype none
`include "idct_8x8_level_shift_top_assert.svh"
module idct_8x8_level_shift_props (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic s_axis_tready,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic m_axis_tlast,
  input wire logic [23:0] m_axis_tdata
);
  `IDCT_ASSERT_NXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  `IDCT_ASSERT_NXT(a_lhold, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tlast))
  `IDCT_ASSERT_IMP(a_known, m_axis_tvalid, !$isunknown({m_axis_tdata, m_axis_tlast}))
  `IDCT_ASSERT_NXT(a_last, m_axis_tvalid && m_axis_tready && m_axis_tlast, !m_axis_tvalid)
endmodule
bind idct_8x8_level_shift_top idct_8x8_level_shift_props u_chk (.*);
`default_nettype wire

// ===== test/idct_8x8_level_shift_checker.sv =====
// Checker for the 8x8 inverse DCT: tracks the channels, predicts samples, compares.
`default_nettype none
module idct_8x8_level_shift_checker (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_valid_i,
  input  wire logic        s_ready_i,
  input  wire logic [15:0] s_data_i,
  input  wire logic        m_valid_i,
  input  wire logic        m_ready_i,
  input  wire logic [23:0] m_data_i,
  input  wire logic        m_last_i,
  input  wire logic        cfg_valid_i,
  input  wire logic        cfg_ready_i,
  input  wire logic [4:0]  cfg_data_i,
  output int               fail_count_o,
  output int               pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [23:0] sample;
    logic        last;
  } sample_beat_t;

  // 0.5*cos(k*pi/16) with 30 fraction bits
  localparam longint HalfCosQ30 [9] = '{536870912, 526555088, 496004047, 446391850,
                                        379625062, 298269498, 205451603, 104738319, 0};
  localparam longint HalfC0Q30 = 379625062;

  longint       basis_q14 [8][8];
  longint       coef_buf [64];
  longint       row_buf [64];
  int           coef_cnt;
  logic [4:0]   precision;
  sample_beat_t sample_fifo [$];

  initial begin
    int m;
    bit neg;
    longint v;
    for (int x = 0; x < 8; x++) begin
      for (int u = 0; u < 8; u++) begin
        if (u == 0) begin
          v = (HalfC0Q30 + (64'sd1 << 15)) >>> 16;
        end else begin
          m = ((2 * x + 1) * u) & 31;
          neg = 1'b0;
          if (m > 16) m = 32 - m;
          if (m > 8) begin
            m = 16 - m;
            neg = 1'b1;
          end
          v = (HalfCosQ30[m] + (64'sd1 << 15)) >>> 16;
          if (neg) v = -v;
        end
        basis_q14[x][u] = v;
      end
    end
  end

  function automatic longint round_floor(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic longint clip24(longint v);
    if (v > 64'sd8388607) return 64'sd8388607;
    if (v < -64'sd8388608) return -64'sd8388608;
    return v;
  endfunction

  task automatic predict_block_samples();
    longint acc;
    longint offset;
    sample_beat_t b;
    for (int y = 0; y < 8; y++)
      for (int x = 0; x < 8; x++) begin
        acc = 0;
        for (int k = 0; k < 8; k++) acc += coef_buf[y * 8 + k] * basis_q14[x][k];
        row_buf[y * 8 + x] = clip24(round_floor(acc, 10));
      end
    offset = (precision == 0) ? 0 : (64'sd1 <<< (precision - 1)) * 16;
    for (int y = 0; y < 8; y++)
      for (int x = 0; x < 8; x++) begin
        acc = 0;
        for (int k = 0; k < 8; k++) acc += row_buf[k * 8 + x] * basis_q14[y][k];
        b.sample = 24'(clip24(round_floor(acc, 14) + offset));
        b.last   = (y == 7 && x == 7);
        sample_fifo.push_back(b);
      end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sample_beat_t exp_b;
    if (!rst_ni) begin
      coef_cnt     <= 0;
      precision    <= 5'd8;
      fail_count_o <= 0;
      sample_sweep: begin end
    end else begin
      if (cfg_valid_i && cfg_ready_i) precision <= cfg_data_i;
      if (s_valid_i && s_ready_i) begin
        coef_buf[coef_cnt] = longint'($signed(s_data_i));
        if (coef_cnt == 63) begin
          coef_cnt <= 0;
          predict_block_samples();
        end else begin
          coef_cnt <= coef_cnt + 1;
        end
      end
      if (m_valid_i && m_ready_i) begin
        if (sample_fifo.size() == 0) begin
          $display("%0t: unexpected sample beat, actual sample %h last %b",
                   $time, m_data_i, m_last_i);
          fail_count_o <= fail_count_o + 1;
        end else begin
          exp_b = sample_fifo.pop_front();
          if (exp_b.sample !== m_data_i || exp_b.last !== m_last_i) begin
            $display("%0t: mismatch, expected sample %h last %b, actual sample %h last %b",
                     $time, exp_b.sample, exp_b.last, m_data_i, m_last_i);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
    end
  end

  assign pending_o = sample_fifo.size();
endmodule
`default_nettype wire

// ===== test/tb_idct_8x8_level_shift_top.sv =====
// Testbench top: drives coefficient blocks and precision writes, gives the verdict.
`default_nettype none
module tb_idct_8x8_level_shift_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 20000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // [15:0] coefficient
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // [23:0] sample
  logic        m_axis_tlast;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [4:0]  cfg_data_i = '0;
  int          fail_count, pending;
  int          tx_gap_pct = 0, rx_gap_pct = 0;
  bit          rx_hold = 1'b0;
  int          idle_cycles = 0;
  int          blocks_sent = 0;

  always #2ns clk_i = ~clk_i;

  idct_8x8_level_shift_top i_dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i
  );

  idct_8x8_level_shift_checker i_checker (
    .clk_i, .rst_ni,
    .s_valid_i(s_axis_tvalid), .s_ready_i(s_axis_tready), .s_data_i(s_axis_tdata),
    .m_valid_i(m_axis_tvalid), .m_ready_i(m_axis_tready), .m_data_i(m_axis_tdata),
    .m_last_i(m_axis_tlast),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_data_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= !rx_hold && ($urandom_range(99) >= rx_gap_pct);
  end

  // watchdog on cycles without any beat
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("idct_8x8_level_shift_top verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic push_coef(input logic [15:0] c);
    while ($urandom_range(99) < tx_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(negedge clk_i);
    while (!s_axis_tready) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(3))
      0: return 16'($urandom);
      1: return 16'($urandom_range(127)) - 16'd64;
      2: return 16'd0;
      default: return 16'($urandom_range(2047)) - 16'd1024;
    endcase
  endfunction

  task automatic push_random_block();
    for (int i = 0; i < 64; i++) push_coef(rand_coef());
    blocks_sent++;
  endtask

  // sender pause until every sample is back, then settle before a register write
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_precision(input logic [4:0] p);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= p;
    @(negedge clk_i);
    while (!cfg_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    tx_gap_pct = 22;
    rx_gap_pct = 52;
    write_precision(5'd0);
    // extremes, sign bits and single-bit patterns
    for (int i = 0; i < 64; i++) begin
      if (i < 16) push_coef(i[0] ? 16'h8000 : 16'h7fff);
      else if (i < 32) push_coef(16'h1 << (i - 16));
      else if (i < 40) push_coef(16'hffff);
      else push_coef(16'h0);
    end
    blocks_sent++;
    drain();
    write_precision(5'd31);
    push_random_block();
    drain();

    tx_gap_pct = 52;
    rx_gap_pct = 22;
    write_precision(5'd2);
    // long receiver hold-off while two blocks are offered
    fork
      begin
        rx_hold = 1'b1;
        repeat (3000) @(posedge clk_i);
        rx_hold = 1'b0;
      end
      begin
        push_random_block();
        push_random_block();
      end
    join
    drain();

    tx_gap_pct = 0;
    rx_gap_pct = 0;
    write_precision(5'd16);
    push_random_block();
    drain();
    write_precision(5'd8);
    push_random_block();
    drain();

    $display("covered %0d blocks (%0d coefficients), precisions 0/31/2/16/8, stalls",
             blocks_sent, blocks_sent * 64);
    if (fail_count == 0 && pending == 0) begin
      $display("idct_8x8_level_shift_top verification clean");
    end else begin
      $display("idct_8x8_level_shift_top verification failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
